@@ rtl/ldc_pkg.sv @@
// Shared types and constants for the load event detector.
// Used by every rtl module of the block; depends on nothing.
package ldc_pkg;

   localparam int unsigned CurrentWidth = 16;
   localparam int unsigned PowerWidth   = 24;
   localparam int unsigned TimeWidth    = 32;
   localparam int unsigned LevelWidth   = 16;
   localparam int unsigned CoolWidth    = 16;

   localparam int unsigned EVENT_KINDS = 3;

   // event kinds, also the slot order of the cooldown bank
   localparam int unsigned KIND_SPIKE      = 0;
   localparam int unsigned KIND_OVERLOAD   = 1;
   localparam int unsigned KIND_POWER_DOWN = 2;

   // configuration port
   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 24;

   localparam logic [CsrIndexWidth-1:0] CSR_OVERLOAD_LIMIT = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_SPIKE_DELTA    = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_ACTIVE_LEVEL   = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_ZERO_LEVEL     = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_COOLDOWN       = 3'd4;

   localparam logic [CurrentWidth-1:0] OVERLOAD_LIMIT_RESET = 16'd10000;
   localparam logic [PowerWidth-1:0]   SPIKE_DELTA_RESET    = 24'd500000;
   localparam logic [LevelWidth-1:0]   ACTIVE_LEVEL_RESET   = 16'd50;
   localparam logic [LevelWidth-1:0]   ZERO_LEVEL_RESET     = 16'd10;
   localparam logic [CoolWidth-1:0]    COOLDOWN_RESET       = 16'd10;

   // stream payload widths
   localparam int unsigned ReqDataWidth = 72;
   localparam int unsigned RspDataWidth = 40;

   typedef struct packed {
      logic [CurrentWidth-1:0] overload_current_limit;
      logic [PowerWidth-1:0]   spike_power_delta;
      logic [LevelWidth-1:0]   active_level;
      logic [LevelWidth-1:0]   zero_level;
      logic [CoolWidth-1:0]    cooldown_seconds;
   } cfg_type;

   typedef struct packed {
      logic                    sample_valid;
      logic [CurrentWidth-1:0] current_ma;
      logic [PowerWidth-1:0]   power_mw;
      logic [TimeWidth-1:0]    sample_time;
   } sample_type;

   // detector verdict for the sample in the input register
   typedef struct packed {
      logic                   taken;
      logic [EVENT_KINDS-1:0] fire;
      logic [TimeWidth-1:0]   sample_time;
   } trig_type;

   typedef struct packed {
      logic                 sample_taken;
      logic                 spike_event;
      logic                 overload_event;
      logic                 power_down_event;
      logic [TimeWidth-1:0] event_time;
   } result_type;

endpackage

@@ rtl/ldc_csr.sv @@
// Configuration register file for the load event detector.
// Depends on ldc_pkg.
module ldc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [ldc_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [ldc_pkg::CsrDataWidth-1:0]  csr_wdata,
   output ldc_pkg::cfg_type                  cfg
);

   ldc_pkg::cfg_type cfg_ff;
   ldc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            ldc_pkg::CSR_OVERLOAD_LIMIT:
               cfg_in.overload_current_limit = csr_wdata[ldc_pkg::CurrentWidth-1:0];
            ldc_pkg::CSR_SPIKE_DELTA:
               cfg_in.spike_power_delta = csr_wdata[ldc_pkg::PowerWidth-1:0];
            ldc_pkg::CSR_ACTIVE_LEVEL:
               cfg_in.active_level = csr_wdata[ldc_pkg::LevelWidth-1:0];
            ldc_pkg::CSR_ZERO_LEVEL:
               cfg_in.zero_level = csr_wdata[ldc_pkg::LevelWidth-1:0];
            ldc_pkg::CSR_COOLDOWN:
               cfg_in.cooldown_seconds = csr_wdata[ldc_pkg::CoolWidth-1:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.overload_current_limit <= ldc_pkg::OVERLOAD_LIMIT_RESET;
         cfg_ff.spike_power_delta      <= ldc_pkg::SPIKE_DELTA_RESET;
         cfg_ff.active_level           <= ldc_pkg::ACTIVE_LEVEL_RESET;
         cfg_ff.zero_level             <= ldc_pkg::ZERO_LEVEL_RESET;
         cfg_ff.cooldown_seconds       <= ldc_pkg::COOLDOWN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/ldc_detect.sv @@
// Event detection against the previous taken sample; holds the baseline state.
// Depends on ldc_pkg.
module ldc_detect (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  ldc_pkg::sample_type sample,
   input  ldc_pkg::cfg_type    cfg,
   output ldc_pkg::trig_type   trig
);

   logic [ldc_pkg::CurrentWidth-1:0] prev_current_ff, prev_current_in;
   logic [ldc_pkg::PowerWidth-1:0]   prev_power_ff, prev_power_in;
   logic [ldc_pkg::TimeWidth-1:0]    prev_time_ff, prev_time_in;
   logic                             baseline_ff, baseline_in;
   logic                             latch_ff, latch_in;

   logic                           over_now;
   logic                           first;
   logic                           fresh;
   logic [ldc_pkg::PowerWidth-1:0] rise;
   logic                           spike_hit;
   logic                           prev_active;
   logic                           now_zero;

   always_comb begin
      over_now = sample.current_ma > cfg.overload_current_limit;
      first    = sample.sample_valid && !baseline_ff;
      fresh    = sample.sample_valid && baseline_ff && (sample.sample_time != prev_time_ff);
      rise     = sample.power_mw - prev_power_ff;
      spike_hit = (sample.power_mw > prev_power_ff) && (rise > cfg.spike_power_delta);
      prev_active = (prev_current_ff > cfg.active_level) ||
                    (prev_power_ff > {{(ldc_pkg::PowerWidth-ldc_pkg::LevelWidth){1'b0}},
                                      cfg.active_level});
      now_zero = (sample.current_ma <= cfg.zero_level) &&
                 (sample.power_mw <= {{(ldc_pkg::PowerWidth-ldc_pkg::LevelWidth){1'b0}},
                                      cfg.zero_level});

      trig.taken       = first || fresh;
      trig.sample_time = sample.sample_time;
      trig.fire        = '0;
      trig.fire[ldc_pkg::KIND_SPIKE]      = fresh && spike_hit;
      trig.fire[ldc_pkg::KIND_OVERLOAD]   = fresh && over_now && !latch_ff;
      trig.fire[ldc_pkg::KIND_POWER_DOWN] = fresh && prev_active && now_zero;

      prev_current_in = prev_current_ff;
      prev_power_in   = prev_power_ff;
      prev_time_in    = prev_time_ff;
      baseline_in     = baseline_ff;
      latch_in        = latch_ff;
      if (step && (first || fresh)) begin
         prev_current_in = sample.current_ma;
         prev_power_in   = sample.power_mw;
         prev_time_in    = sample.sample_time;
         baseline_in     = 1'b1;
         latch_in        = over_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_current_ff <= '0;
         prev_power_ff   <= '0;
         prev_time_ff    <= '0;
         baseline_ff     <= 1'b0;
         latch_ff        <= 1'b0;
      end else begin
         prev_current_ff <= prev_current_in;
         prev_power_ff   <= prev_power_in;
         prev_time_ff    <= prev_time_in;
         baseline_ff     <= baseline_in;
         latch_ff        <= latch_in;
      end
   end

endmodule

@@ rtl/ldc_cooldown.sv @@
// One cooldown slot: last emission time of one event kind and its gate.
// Depends on ldc_pkg.
module ldc_cooldown (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic                           fire,
   input  logic [ldc_pkg::TimeWidth-1:0]  sample_time,
   input  logic [ldc_pkg::CoolWidth-1:0]  cooldown_seconds,
   output logic                           emit
);

   logic [ldc_pkg::TimeWidth-1:0] last_ff, last_in;
   logic [ldc_pkg::TimeWidth-1:0] gap;
   logic                          open;

   always_comb begin
      gap  = sample_time - last_ff;
      // a zero time means never emitted; otherwise require a later time past the window
      open = (last_ff == '0) ||
             ((sample_time > last_ff) &&
              (gap >= {{(ldc_pkg::TimeWidth-ldc_pkg::CoolWidth){1'b0}}, cooldown_seconds}));
      emit    = fire && open;
      last_in = (step && emit) ? sample_time : last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
      end else begin
         last_ff <= last_in;
      end
   end

endmodule

@@ rtl/load_event_detector_with_cooldown_core.sv @@
// Load event detector: one sample enters per clock while rsp_tready is high,
// and its result passes the input register, the detect and cooldown logic and
// the result register. The only loop is the registered update of the baseline
// and the per-kind emission times. req_tready follows rsp_tready combinationally
// when both registers are full. Write configuration only while no sample is in
// flight.
module load_event_detector_with_cooldown_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [15:0] current_ma, [39:16] power_mw, [71:40] sample_time
   input  logic [ldc_pkg::ReqDataWidth-1:0]  req_tdata,
   // [0] sample_valid
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] sample_taken, [1] spike_event, [2] overload_event,
   // [3] power_down_event, [35:4] event_time, [39:36] zero
   output logic [ldc_pkg::RspDataWidth-1:0]  rsp_tdata,
   input  logic                              csr_we,
   input  logic [ldc_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [ldc_pkg::CsrDataWidth-1:0]  csr_wdata
);

   ldc_pkg::cfg_type    cfg;
   ldc_pkg::sample_type in_ff, in_in;
   logic                in_valid_ff, in_valid_in;
   ldc_pkg::result_type rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   ldc_pkg::trig_type   trig;
   logic [ldc_pkg::EVENT_KINDS-1:0] emit;
   logic                advance;
   logic                req_xfer;

   ldc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ldc_detect u_detect (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .sample (in_ff),
      .cfg    (cfg),
      .trig   (trig)
   );

   for (genvar k = 0; k < ldc_pkg::EVENT_KINDS; k++) begin : g_cool
      ldc_cooldown u_cool (
         .clock            (clock),
         .reset            (reset),
         .step             (advance),
         .fire             (trig.fire[k]),
         .sample_time      (trig.sample_time),
         .cooldown_seconds (cfg.cooldown_seconds),
         .emit             (emit[k])
      );
   end

   always_comb begin
      advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
      req_tready = !in_valid_ff || advance;
      req_xfer   = req_tvalid && req_tready;

      in_valid_in = req_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      in_in       = in_ff;
      if (req_xfer) begin
         in_in.sample_valid = req_tuser;
         in_in.current_ma   = req_tdata[15:0];
         in_in.power_mw     = req_tdata[39:16];
         in_in.sample_time  = req_tdata[71:40];
      end

      rsp_valid_in = advance ? 1'b1 : ((rsp_valid_ff && rsp_tready) ? 1'b0 : rsp_valid_ff);
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_in.sample_taken     = trig.taken;
         rsp_in.spike_event      = emit[ldc_pkg::KIND_SPIKE];
         rsp_in.overload_event   = emit[ldc_pkg::KIND_OVERLOAD];
         rsp_in.power_down_event = emit[ldc_pkg::KIND_POWER_DOWN];
         rsp_in.event_time       = trig.taken ? trig.sample_time : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_ff.event_time, rsp_ff.power_down_event,
                        rsp_ff.overload_event, rsp_ff.spike_event, rsp_ff.sample_taken};

endmodule

@@ rtl/ldc_checker.sv @@
// Port-level checks for the load event detector, bound to the top level.
// Depends on ldc_pkg and load_event_detector_with_cooldown_core.
module ldc_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [ldc_pkg::RspDataWidth-1:0] rsp_tdata
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or dropped");

   // a result not taken carries no event and no time
   a_untaken_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[ldc_pkg::RspDataWidth-1:1] == '0)
      else $error("untaken sample shows events or time");

   // a fresh result follows an input transfer through the input and result registers
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result without a matching input transfer");

   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind load_event_detector_with_cooldown_core ldc_checker u_ldc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ tb/load_event_checker.sv @@
// Result checker for the load event detector: watches the sample, result and
// register ports, predicts every result and compares it field by field.
// Depends on ldc_pkg for widths, register indexes and event kinds.
module load_event_checker
   import ldc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [ReqDataWidth-1:0]  req_tdata,
   input  logic                     req_tuser,
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [RspDataWidth-1:0]  rsp_tdata,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata,
   output int unsigned              pending,
   output int unsigned              fail_count
);

   cfg_type                 settings;
   logic [CurrentWidth-1:0] last_current;
   logic [PowerWidth-1:0]   last_power;
   logic [TimeWidth-1:0]    last_time;
   logic                    have_baseline;
   logic                    over_latch;
   logic [TimeWidth-1:0]    fired_at [EVENT_KINDS];
   result_type              due_q [$];
   int unsigned             errs = 0;

   // a zero emission time means the kind has never fired
   function automatic logic cooling(int unsigned kind, logic [TimeWidth-1:0] t);
      if (fired_at[kind] == '0) return 1'b0;
      if (t <= fired_at[kind]) return 1'b1;
      return (t - fired_at[kind]) < settings.cooldown_seconds;
   endfunction

   function automatic logic fire(int unsigned kind, logic [TimeWidth-1:0] t);
      if (cooling(kind, t)) return 1'b0;
      fired_at[kind] = t;
      return 1'b1;
   endfunction

   function automatic result_type predict_events(sample_type s);
      result_type r;
      logic       over_now;
      r = '0;
      if (!s.sample_valid) return r;
      over_now = s.current_ma > settings.overload_current_limit;
      if (!have_baseline) begin
         have_baseline = 1'b1;
      end else if (s.sample_time != last_time) begin
         if (s.power_mw > last_power &&
             (s.power_mw - last_power) > settings.spike_power_delta)
            r.spike_event = fire(KIND_SPIKE, s.sample_time);
         if (over_now && !over_latch)
            r.overload_event = fire(KIND_OVERLOAD, s.sample_time);
         if ((last_current > settings.active_level || last_power > settings.active_level) &&
             s.current_ma <= settings.zero_level && s.power_mw <= settings.zero_level)
            r.power_down_event = fire(KIND_POWER_DOWN, s.sample_time);
      end else begin
         return r;
      end
      r.sample_taken = 1'b1;
      r.event_time   = s.sample_time;
      over_latch     = over_now;
      last_current   = s.current_ma;
      last_power     = s.power_mw;
      last_time      = s.sample_time;
      return r;
   endfunction

   task automatic check_field(string name, logic [TimeWidth-1:0] want,
                              logic [TimeWidth-1:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         errs++;
      end
   endtask

   always @(posedge clock) begin : watch
      sample_type s;
      result_type want;
      if (reset) begin
         settings = '{OVERLOAD_LIMIT_RESET, SPIKE_DELTA_RESET, ACTIVE_LEVEL_RESET,
                      ZERO_LEVEL_RESET, COOLDOWN_RESET};
         last_current  = '0;
         last_power    = '0;
         last_time     = '0;
         have_baseline = 1'b0;
         over_latch    = 1'b0;
         foreach (fired_at[k]) fired_at[k] = '0;
         due_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_OVERLOAD_LIMIT: settings.overload_current_limit = csr_wdata[CurrentWidth-1:0];
               CSR_SPIKE_DELTA:    settings.spike_power_delta = csr_wdata[PowerWidth-1:0];
               CSR_ACTIVE_LEVEL:   settings.active_level = csr_wdata[LevelWidth-1:0];
               CSR_ZERO_LEVEL:     settings.zero_level = csr_wdata[LevelWidth-1:0];
               CSR_COOLDOWN:       settings.cooldown_seconds = csr_wdata[CoolWidth-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (due_q.size() == 0) begin
               $error("result transfer 0x%0h with no sample outstanding", rsp_tdata);
               errs++;
            end else begin
               want = due_q.pop_front();
               check_field("sample_taken", 32'(want.sample_taken), 32'(rsp_tdata[0]));
               check_field("spike_event", 32'(want.spike_event), 32'(rsp_tdata[1]));
               check_field("overload_event", 32'(want.overload_event),
                           32'(rsp_tdata[2]));
               check_field("power_down_event", 32'(want.power_down_event),
                           32'(rsp_tdata[3]));
               check_field("event_time", want.event_time, rsp_tdata[35:4]);
               check_field("reserved", '0, 32'(rsp_tdata[RspDataWidth-1:36]));
            end
         end
         if (req_tvalid && req_tready) begin
            s.sample_valid = req_tuser;
            s.current_ma   = req_tdata[15:0];
            s.power_mw     = req_tdata[39:16];
            s.sample_time  = req_tdata[71:40];
            due_q.push_back(predict_events(s));
         end
      end
      pending    <= due_q.size();
      fail_count <= errs;
   end

endmodule

@@ tb/tb.sv @@
// Top of the load event detector testbench: clock, reset, sample stimulus,
// register programming and the verdict. Depends on ldc_pkg, the detector core
// and load_event_checker, which does all prediction and comparison.
module tb;
   import ldc_pkg::*;

   localparam int unsigned WatchdogLimit = 2000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   // [15:0] current_ma, [39:16] power_mw, [71:40] sample_time
   logic [ReqDataWidth-1:0]  req_tdata = '0;
   // [0] sample_valid
   logic                     req_tuser = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   // [0] sample_taken, [1] spike_event, [2] overload_event,
   // [3] power_down_event, [35:4] event_time, [39:36] zero
   logic [RspDataWidth-1:0]  rsp_tdata;
   logic                     csr_we = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_wdata = '0;

   int unsigned pending;
   int unsigned fail_count;
   int unsigned quiet_cycles = 0;
   logic        steady = 1'b0;
   logic        squeeze = 1'b0;

   // stimulus shaping only: current settings and the last valid sample
   cfg_type              plan = '{OVERLOAD_LIMIT_RESET, SPIKE_DELTA_RESET, ACTIVE_LEVEL_RESET,
                                  ZERO_LEVEL_RESET, COOLDOWN_RESET};
   logic [TimeWidth-1:0]  stim_time = '0;
   logic [PowerWidth-1:0] stim_power = '0;

   load_event_detector_with_cooldown_core dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_we, .csr_index, .csr_wdata
   );

   load_event_checker events_chk (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_we, .csr_index, .csr_wdata,
      .pending, .fail_count
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic sample_type make_sample(logic valid, logic [15:0] cur,
                                              logic [23:0] pwr, logic [31:0] t);
      sample_type s;
      s.sample_valid = valid;
      s.current_ma   = cur;
      s.power_mw     = pwr;
      s.sample_time  = t;
      return s;
   endfunction

   function automatic longint clamp(longint v, longint hi);
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic cfg_type random_cfg();
      cfg_type c;
      c.overload_current_limit = 16'($urandom_range(100, 60000));
      c.spike_power_delta      = 24'($urandom_range(1000, 3000000));
      c.active_level           = 16'($urandom_range(20, 600));
      c.zero_level             = 16'($urandom_range(0, 100));
      c.cooldown_seconds       = 16'($urandom_range(0, 30));
      return c;
   endfunction

   // mostly rising times near the cooldown window, loads around the thresholds
   function automatic sample_type random_sample();
      sample_type  s;
      int unsigned span;
      int unsigned roll;
      span = 2 * plan.cooldown_seconds + 2;
      if ($urandom_range(0, 99) < 5)
         return make_sample(1'b0, 16'($urandom()), 24'($urandom()), $urandom());
      s.sample_valid = 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 8)
         s.sample_time = stim_time;
      else if (roll < 88)
         s.sample_time = stim_time + $urandom_range(1, span);
      else if (roll < 95)
         s.sample_time = stim_time - $urandom_range(1, span);
      else
         s.sample_time = stim_time + $urandom_range(span, 32'h0010_0000);
      if ($urandom_range(0, 3) == 0) begin
         s.current_ma = 16'($urandom_range(0, plan.zero_level));
         s.power_mw   = 24'($urandom_range(0, plan.zero_level));
         return s;
      end
      roll = $urandom_range(0, 99);
      if (roll < 20)
         s.current_ma = 16'($urandom_range(0, plan.zero_level));
      else if (roll < 50)
         s.current_ma = 16'(clamp(longint'(plan.overload_current_limit) +
                                  longint'($urandom_range(0, 4)) - 2, 16'hFFFF));
      else if (roll < 75)
         s.current_ma = 16'($urandom());
      else
         s.current_ma = 16'($urandom_range(plan.active_level, 16'hFFFF));
      roll = $urandom_range(0, 99);
      if (roll < 20)
         s.power_mw = 24'($urandom_range(0, plan.zero_level));
      else if (roll < 50)
         s.power_mw = 24'(clamp(longint'(stim_power) + longint'(plan.spike_power_delta) +
                                longint'($urandom_range(0, 4)) - 2, 24'hFFFFFF));
      else if (roll < 75)
         s.power_mw = 24'($urandom());
      else if (roll < 85)
         s.power_mw = 24'hFFFFFF;
      else
         s.power_mw = 24'($urandom_range(0, 2 * plan.active_level + 2));
      return s;
   endfunction

   // offer one sample and hold it until the transfer
   task automatic send_sample(input sample_type s);
      if (!steady && $urandom_range(0, 99) < 10) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= s.sample_valid;
      req_tdata  <= {s.sample_time, s.power_mw, s.current_ma};
      do @(posedge clock); while (!req_tready);
      if (s.sample_valid) begin
         stim_time  = s.sample_time;
         stim_power = s.power_mw;
      end
   endtask

   task automatic run_random(input int count, input int squeeze_after);
      for (int i = 0; i < count; i++) begin
         if (i == squeeze_after) squeeze <= 1'b1;
         send_sample(random_sample());
      end
   endtask

   // drop valid and wait for every outstanding result
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   // 16-bit registers get noise in the unused upper byte
   task automatic program_cfg(input cfg_type c);
      plan = c;
      csr_we    <= 1'b1;
      csr_index <= CSR_OVERLOAD_LIMIT;
      csr_wdata <= {8'($urandom()), c.overload_current_limit};
      @(posedge clock);
      csr_index <= CSR_SPIKE_DELTA;
      csr_wdata <= c.spike_power_delta;
      @(posedge clock);
      csr_index <= CSR_ACTIVE_LEVEL;
      csr_wdata <= {8'($urandom()), c.active_level};
      @(posedge clock);
      csr_index <= CSR_ZERO_LEVEL;
      csr_wdata <= {8'($urandom()), c.zero_level};
      @(posedge clock);
      csr_index <= CSR_COOLDOWN;
      csr_wdata <= {8'($urandom()), c.cooldown_seconds};
      @(posedge clock);
      // unmapped index, must be ignored
      csr_index <= 3'(CSR_COOLDOWN + $urandom_range(1, 3));
      csr_wdata <= 24'($urandom());
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : receiver
      int unsigned hold_left;
      logic        squeezed;
      hold_left = 0;
      squeezed  = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left != 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (squeeze && !squeezed) begin
            // long hold-off so the core backs up into its input
            squeezed = 1'b1;
            hold_left = 79;
            rsp_tready <= 1'b0;
         end else if (steady) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= 10);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WatchdogLimit) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      cfg_type c;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // settings out of reset
      send_sample(make_sample(1'b0, 16'hFFFF, 24'hFFFFFF, 32'hFFFF_FFFF));
      send_sample(make_sample(1'b1, 16'd20000, 24'd100, 32'd7));      // baseline
      send_sample(make_sample(1'b1, 16'd0, 24'd0, 32'd7));            // same time
      send_sample(make_sample(1'b1, 16'd0, 24'd0, 32'd0));            // power-down at zero
      send_sample(make_sample(1'b1, 16'd100, 24'd100, 32'd3));
      send_sample(make_sample(1'b1, 16'd10, 24'd10, 32'd4));          // fires again
      send_sample(make_sample(1'b1, 16'd10001, 24'd600001, 32'd20));
      send_sample(make_sample(1'b1, 16'd10000, 24'd0, 32'd25));       // power drop
      send_sample(make_sample(1'b1, 16'd20000, 24'd600000, 32'd27));  // cooling
      send_sample(make_sample(1'b1, 16'd0, 24'd0, 32'd9));
      send_sample(make_sample(1'b1, 16'd51, 24'd51, 32'd30));
      send_sample(make_sample(1'b1, 16'd0, 24'd0, 32'd14));           // cooldown edge
      send_sample(make_sample(1'b1, 16'hFFFF, 24'hFFFFFF, 32'd1000));
      send_sample(make_sample(1'b1, 16'd0, 24'd0, 32'd1000));
      send_sample(make_sample(1'b1, 16'd0, 24'd0, 32'd12));           // before last emit
      send_sample(make_sample(1'b0, 16'd0, 24'd0, 32'd1500));
      run_random(110, -1);
      settle();

      // all registers at zero
      program_cfg('0);
      send_sample(make_sample(1'b1, 16'd1, 24'd1, stim_time + 32'd2000));
      send_sample(make_sample(1'b1, 16'd0, 24'd0, stim_time + 32'd1));
      send_sample(make_sample(1'b1, 16'd1, 24'd2, stim_time + 32'd1));
      run_random(110, -1);
      settle();

      // all registers at maximum
      c.overload_current_limit = 16'hFFFF;
      c.spike_power_delta      = 24'hFFFFFF;
      c.active_level           = 16'hFFFF;
      c.zero_level             = 16'hFFFF;
      c.cooldown_seconds       = 16'hFFFF;
      program_cfg(c);
      send_sample(make_sample(1'b1, 16'hFFFF, 24'hFFFFFF, stim_time + 32'd3000));
      send_sample(make_sample(1'b1, 16'hFFFF, 24'h00FFFF, stim_time + 32'd1));
      run_random(60, -1);
      settle();

      program_cfg(random_cfg());
      run_random(130, 30);
      settle();

      // no idling on either side
      steady <= 1'b1;
      program_cfg(random_cfg());
      run_random(130, -1);
      settle();
      steady <= 1'b0;

      program_cfg(random_cfg());
      run_random(110, -1);
      send_sample(make_sample(1'b1, 16'hFFFF, 24'hFFFFFF, 32'hFFFF_FFFF));
      send_sample(make_sample(1'b1, 16'd0, 24'd0, 32'hFFFF_FFFF));
      settle();
      repeat (4) @(posedge clock);

      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/ldc_pkg.sv
rtl/ldc_csr.sv
rtl/ldc_detect.sv
rtl/ldc_cooldown.sv
rtl/load_event_detector_with_cooldown_core.sv
rtl/ldc_checker.sv
tb/load_event_checker.sv
tb/tb.sv
